@@ rtl/slcg_pkg.sv @@
package slcg_pkg;

  localparam int SITE_W    = 12;
  localparam int SIDE_W    = 7;
  localparam int CNT_W     = 14;
  localparam int COEF_W    = 32;
  localparam int OP_W      = 2;
  localparam int NBR_N     = 4;
  localparam int TERM_N    = 3;
  localparam int SLOT_N    = NBR_N * TERM_N;
  localparam int QDEPTH    = 4;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_COLUMNS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROWS     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIODIC = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NN_X     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NN_Z     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_NNN_X    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_NNN_Z    = 3'd7;

  // operator codes
  localparam logic [OP_W-1:0] OP_RAISE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOWER = 2'd1;
  localparam logic [OP_W-1:0] OP_Z     = 2'd2;

  // neighbour slots, in output order
  localparam int NB_UP        = 0;
  localparam int NB_RIGHT     = 1;
  localparam int NB_UPLEFT    = 2;
  localparam int NB_UPRIGHT   = 3;
  localparam int NB_NNN_FIRST = NB_UPLEFT;

  // term kinds, in output order
  localparam int TERM_PM = 0;
  localparam int TERM_MP = 1;
  localparam int TERM_ZZ = 2;

  typedef struct packed {
    logic [SIDE_W-1:0] lx;
    logic [SIDE_W-1:0] ly;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  ns;
    logic              px;
    logic              py;
    logic [COEF_W-1:0] nn_x;
    logic [COEF_W-1:0] nn_z;
    logic [COEF_W-1:0] nnn_x;
    logic [COEF_W-1:0] nnn_z;
  } cfg_t;

  typedef struct packed {
    logic [NBR_N-1:0][SITE_W-1:0] lo;
    logic [NBR_N-1:0][SITE_W-1:0] hi;
    logic [SLOT_N-1:0]            mask;
  } entry_t;

  function automatic logic [COEF_W-1:0] term_coef(input cfg_t c, input int k, input int t);
    logic [COEF_W-1:0] v;
    if (k < NB_NNN_FIRST) begin
      v = (t == TERM_ZZ) ? c.nn_z : c.nn_x;
    end else begin
      v = (t == TERM_ZZ) ? c.nnn_z : c.nnn_x;
    end
    return v;
  endfunction

  function automatic logic [OP_W-1:0] left_op(input int t);
    logic [OP_W-1:0] v;
    case (t)
      TERM_PM: v = OP_RAISE;
      TERM_MP: v = OP_LOWER;
      default: v = OP_Z;
    endcase
    return v;
  endfunction

  function automatic logic [OP_W-1:0] right_op(input int t);
    logic [OP_W-1:0] v;
    case (t)
      TERM_PM: v = OP_LOWER;
      TERM_MP: v = OP_RAISE;
      default: v = OP_Z;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/slcg_front.sv @@
module slcg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  slcg_pkg::cfg_t                cfg,
  input  logic                          push,
  input  logic [slcg_pkg::SITE_W-1:0]   site_index,
  output logic                          stall,
  output logic                          out_valid,
  output slcg_pkg::entry_t              out_entry,
  input  logic                          out_full
);

  localparam int SW = slcg_pkg::SITE_W;
  localparam int XW = slcg_pkg::SIDE_W;
  localparam int CW = slcg_pkg::CNT_W;
  localparam int DW = SW + XW;

  typedef struct packed {
    logic          inr;
    logic [SW-1:0] is;
    logic [SW-1:0] rem;
    logic [XW-1:0] q;
  } dstage_t;

  typedef struct packed {
    logic                            inr;
    logic [SW-1:0]                   is;
    logic [CW-1:0]                   base_c;
    logic [CW-1:0]                   base_r;
    logic [CW-1:0]                   base_l;
    logic                            odd;
    logic                            odd_r;
    logic                            odd_l;
    logic [XW-1:0]                   y;
    logic [XW-1:0]                   y_m;
    logic [XW-1:0]                   ya;
    logic [XW-1:0]                   ya_m;
    logic [slcg_pkg::NBR_N-1:0]      pre;
  } astage_t;

  // one quotient bit per stage, msb first
  function automatic dstage_t div_step(input dstage_t d, input logic [XW-1:0] ly,
                                       input int k);
    logic [DW-1:0] dvsr;
    dstage_t       n;
    n    = d;
    dvsr = DW'(ly) << k;
    if (DW'(d.rem) >= dvsr) begin
      n.rem  = d.rem - dvsr[SW-1:0];
      n.q[k] = 1'b1;
    end
    return n;
  endfunction

  logic [XW:0]   dv;
  dstage_t       ds [XW+1];
  logic          av;
  astage_t       as;
  logic          bv;
  slcg_pkg::entry_t bs;

  astage_t       a_next;
  slcg_pkg::entry_t b_next;

  assign stall     = bv && out_full;
  assign out_valid = bv;
  assign out_entry = bs;

  // column and row decode, neighbour column bases
  always_comb begin
    logic [XW-1:0] ix, r, ly_m1, lx_m1, jy, jy_m, ixr, ixl;
    logic          top, ix_last, ix_first, up_ok, right_ok, left_ok, nnn_en;
    ix       = ds[XW].q;
    r        = ds[XW].rem[XW-1:0];
    ly_m1    = cfg.ly - XW'(1);
    lx_m1    = cfg.lx - XW'(1);
    jy       = ix[0] ? (ly_m1 - r) : r;
    jy_m     = ix[0] ? r : (ly_m1 - r);
    top      = (jy == ly_m1);
    ix_last  = (ix == lx_m1);
    ix_first = (ix == '0);
    ixr      = ix_last ? '0 : (ix + XW'(1));
    ixl      = ix_first ? lx_m1 : (ix - XW'(1));
    up_ok    = !top || cfg.py;
    right_ok = !ix_last || cfg.px;
    left_ok  = !ix_first || cfg.px;
    nnn_en   = (cfg.lx != XW'(1)) && (cfg.ly != XW'(1));

    a_next.inr    = ds[XW].inr;
    a_next.is     = ds[XW].is;
    a_next.base_c = CW'(ds[XW].is) - CW'(r);
    a_next.base_r = ix_last ? '0 : (a_next.base_c + CW'(cfg.ly));
    a_next.base_l = ix_first ? (cfg.total - CW'(cfg.ly)) : (a_next.base_c - CW'(cfg.ly));
    a_next.odd    = ix[0];
    a_next.odd_r  = ixr[0];
    a_next.odd_l  = ixl[0];
    a_next.y      = jy;
    a_next.y_m    = jy_m;
    a_next.ya     = top ? '0 : (jy + XW'(1));
    a_next.ya_m   = top ? ly_m1 : (jy_m - XW'(1));
    a_next.pre[slcg_pkg::NB_UP]      = up_ok && (cfg.ly != XW'(1));
    a_next.pre[slcg_pkg::NB_RIGHT]   = right_ok && (cfg.lx != XW'(1));
    a_next.pre[slcg_pkg::NB_UPLEFT]  = left_ok && up_ok && nnn_en;
    a_next.pre[slcg_pkg::NB_UPRIGHT] = right_ok && up_ok && nnn_en;
  end

  // neighbour indexes, range check, term mask
  always_comb begin
    logic [slcg_pkg::NBR_N-1:0][CW-1:0] n;
    logic [slcg_pkg::NBR_N-1:0]         keep;
    n[slcg_pkg::NB_UP]      = as.base_c + CW'(as.odd ? as.ya_m : as.ya);
    n[slcg_pkg::NB_RIGHT]   = as.base_r + CW'(as.odd_r ? as.y_m : as.y);
    n[slcg_pkg::NB_UPLEFT]  = as.base_l + CW'(as.odd_l ? as.ya_m : as.ya);
    n[slcg_pkg::NB_UPRIGHT] = as.base_r + CW'(as.odd_r ? as.ya_m : as.ya);
    for (int k = 0; k < slcg_pkg::NBR_N; k++) begin
      keep[k] = as.inr && as.pre[k] && (n[k] < cfg.ns);
      if (n[k] < CW'(as.is)) begin
        b_next.lo[k] = n[k][SW-1:0];
        b_next.hi[k] = as.is;
      end else begin
        b_next.lo[k] = as.is;
        b_next.hi[k] = n[k][SW-1:0];
      end
      for (int t = 0; t < slcg_pkg::TERM_N; t++) begin
        b_next.mask[k*slcg_pkg::TERM_N+t] =
          keep[k] && (slcg_pkg::term_coef(cfg, k, t) != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      av <= 1'b0;
      bv <= 1'b0;
    end else if (!stall) begin
      dv <= {dv[XW-1:0], push};
      av <= dv[XW];
      bv <= av;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      ds[0].inr <= CW'(site_index) < cfg.ns;
      ds[0].is  <= site_index;
      ds[0].rem <= site_index;
      ds[0].q   <= '0;
      for (int s = 0; s < XW; s++) begin
        ds[s+1] <= div_step(ds[s], cfg.ly, XW - 1 - s);
      end
      as <= a_next;
      bs <= b_next;
    end
  end

endmodule

@@ rtl/slcg_queue.sv @@
module slcg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  slcg_pkg::entry_t wdata,
  output logic             full,
  input  logic             rd,
  output logic             avail,
  output slcg_pkg::entry_t rdata
);

  localparam int PTR_W = $clog2(slcg_pkg::QDEPTH);
  localparam int CNT_QW = $clog2(slcg_pkg::QDEPTH + 1);

  slcg_pkg::entry_t   slots [slcg_pkg::QDEPTH];
  logic [PTR_W-1:0]   wp;
  logic [PTR_W-1:0]   rp;
  logic [CNT_QW-1:0]  cnt;
  logic               do_wr;
  logic               do_rd;

  assign full  = (cnt == CNT_QW'(slcg_pkg::QDEPTH));
  assign avail = (cnt != '0);
  assign rdata = slots[rp];
  assign do_wr = wr && !full;
  assign do_rd = rd && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= wp + PTR_W'(1);
      end
      if (do_rd) begin
        rp <= rp + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CNT_QW'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wdata;
    end
  end

endmodule

@@ rtl/slcg_back.sv @@
module slcg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  slcg_pkg::cfg_t                cfg,
  input  logic                          q_avail,
  input  slcg_pkg::entry_t              q_rdata,
  output logic                          q_rd,
  output logic                          empty,
  input  logic                          pop,
  output logic                          term_valid,
  output logic [slcg_pkg::COEF_W-1:0]   coefficient,
  output logic [slcg_pkg::OP_W-1:0]     left_operator,
  output logic [slcg_pkg::SITE_W-1:0]   left_site,
  output logic [slcg_pkg::OP_W-1:0]     right_operator,
  output logic [slcg_pkg::SITE_W-1:0]   right_site,
  output logic                          last_term
);

  localparam int SN = slcg_pkg::SLOT_N;

  logic             cur_v;
  slcg_pkg::entry_t cur;
  logic [SN-1:0]    rem;
  logic             ov;

  logic             out_free;
  logic             emit;
  logic [SN-1:0]    pick;
  logic [SN-1:0]    rem_after;
  logic             last;

  logic [slcg_pkg::COEF_W-1:0] coef_sel;
  logic [slcg_pkg::OP_W-1:0]   lop_sel;
  logic [slcg_pkg::OP_W-1:0]   rop_sel;
  logic [slcg_pkg::SITE_W-1:0] lo_sel;
  logic [slcg_pkg::SITE_W-1:0] hi_sel;

  assign out_free  = !ov || pop;
  assign emit      = cur_v && out_free;
  assign pick      = rem & (~rem + SN'(1));
  assign rem_after = rem & ~pick;
  assign last      = (rem_after == '0);
  assign q_rd      = q_avail && (!cur_v || (emit && last));
  assign empty     = !ov;

  // lowest pending slot; nothing pending gives all-zero term fields
  always_comb begin
    coef_sel = '0;
    lop_sel  = '0;
    rop_sel  = '0;
    lo_sel   = '0;
    hi_sel   = '0;
    for (int p = 0; p < SN; p++) begin
      if (pick[p]) begin
        coef_sel = coef_sel |
          slcg_pkg::term_coef(cfg, p / slcg_pkg::TERM_N, p % slcg_pkg::TERM_N);
        lop_sel  = lop_sel | slcg_pkg::left_op(p % slcg_pkg::TERM_N);
        rop_sel  = rop_sel | slcg_pkg::right_op(p % slcg_pkg::TERM_N);
        lo_sel   = lo_sel | cur.lo[p / slcg_pkg::TERM_N];
        hi_sel   = hi_sel | cur.hi[p / slcg_pkg::TERM_N];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
      ov    <= 1'b0;
    end else begin
      if (q_rd) begin
        cur_v <= 1'b1;
      end else if (emit && last) begin
        cur_v <= 1'b0;
      end
      if (emit) begin
        ov <= 1'b1;
      end else if (pop) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_rdata;
      rem <= q_rdata.mask;
    end else if (emit) begin
      rem <= rem_after;
    end
    if (emit) begin
      term_valid     <= |pick;
      coefficient    <= coef_sel;
      left_operator  <= lop_sel;
      left_site      <= lo_sel;
      right_operator <= rop_sel;
      right_site     <= hi_sel;
      last_term      <= last;
    end
  end

endmodule

@@ rtl/snake_lattice_coupling_term_generator_unit.sv @@
// snake-lattice coupling term generator: each pushed site index (snake order on an
// lx by ly lattice) is expanded into its exchange terms with the up, right, upper-left
// and upper-right neighbours, S+S-, S-S+ and SzSz per neighbour, each only when its
// coupling is nonzero, up to twelve result beats per site; a site with no term gives
// one beat with term_valid low and last_term high. the front is a pipeline of
// SIDE_W + 3 = 10 stages (an input register, a 7-stage restoring divider for column
// and row, then two stages of neighbour decode) and takes a new site every cycle while
// the 4-entry queue in front of the back end has room. the back end sends one result
// beat per cycle while its output register is empty or being popped. configuration
// writes are taken at any cycle (ready is tied high) and must only happen while idle.
module snake_lattice_coupling_term_generator_unit #(
  parameter int MAX_SIDE  = 64,
  parameter int MAX_SITES = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input queue side
  input  logic                                   push,
  output logic                                   full,
  input  logic [slcg_pkg::SITE_W-1:0]            site_index,
  // result queue side
  output logic                                   empty,
  input  logic                                   pop,
  output logic                                   term_valid,
  output logic signed [slcg_pkg::COEF_W-1:0]     coefficient,
  output logic [slcg_pkg::OP_W-1:0]              left_operator,
  output logic [slcg_pkg::SITE_W-1:0]            left_site,
  output logic [slcg_pkg::OP_W-1:0]              right_operator,
  output logic [slcg_pkg::SITE_W-1:0]            right_site,
  output logic                                   last_term,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [slcg_pkg::REG_IDX_W-1:0]         cfg_index,
  input  logic [slcg_pkg::DATA_W-1:0]            cfg_data
);

  localparam int XW = slcg_pkg::SIDE_W;
  localparam int CW = slcg_pkg::CNT_W;

  // programmed registers
  logic [XW-1:0]                 lattice_columns;
  logic [XW-1:0]                 lattice_rows;
  logic [1:0]                    periodic_mask;
  logic [12:0]                   active_sites;
  logic [slcg_pkg::COEF_W-1:0]   nn_exchange;
  logic [slcg_pkg::COEF_W-1:0]   nn_ising;
  logic [slcg_pkg::COEF_W-1:0]   nnn_exchange;
  logic [slcg_pkg::COEF_W-1:0]   nnn_ising;

  slcg_pkg::cfg_t                cfg;

  logic                          fr_valid;
  slcg_pkg::entry_t              fr_entry;
  logic                          q_full;
  logic                          q_rd;
  logic                          q_avail;
  slcg_pkg::entry_t              q_rdata;
  logic [slcg_pkg::COEF_W-1:0]   coef_raw;

  assign cfg_ready   = 1'b1;
  assign coefficient = coef_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_columns <= XW'(1);
      lattice_rows    <= XW'(1);
      periodic_mask   <= '0;
      active_sites    <= '0;
      nn_exchange     <= '0;
      nn_ising        <= '0;
      nnn_exchange    <= '0;
      nnn_ising       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slcg_pkg::REG_COLUMNS:  lattice_columns <= cfg_data[XW-1:0];
        slcg_pkg::REG_ROWS:     lattice_rows    <= cfg_data[XW-1:0];
        slcg_pkg::REG_PERIODIC: periodic_mask   <= cfg_data[1:0];
        slcg_pkg::REG_ACTIVE:   active_sites    <= cfg_data[12:0];
        slcg_pkg::REG_NN_X:     nn_exchange     <= cfg_data;
        slcg_pkg::REG_NN_Z:     nn_ising        <= cfg_data;
        slcg_pkg::REG_NNN_X:    nnn_exchange    <= cfg_data;
        slcg_pkg::REG_NNN_Z:    nnn_ising       <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived lattice shape: sides clamped to 1..MAX_SIDE, active count limited
  // to the lattice size and MAX_SITES, zero meaning the whole lattice
  always_comb begin
    logic [CW-1:0] ns_raw;
    cfg.lx = (lattice_columns == '0) ? XW'(1) : lattice_columns;
    if (int'(lattice_columns) > MAX_SIDE) begin
      cfg.lx = XW'(MAX_SIDE);
    end
    cfg.ly = (lattice_rows == '0) ? XW'(1) : lattice_rows;
    if (int'(lattice_rows) > MAX_SIDE) begin
      cfg.ly = XW'(MAX_SIDE);
    end
    cfg.total = CW'(cfg.lx) * CW'(cfg.ly);
    ns_raw = (active_sites == '0) ? cfg.total : CW'(active_sites);
    if (ns_raw > cfg.total) begin
      ns_raw = cfg.total;
    end
    if (int'(ns_raw) > MAX_SITES) begin
      ns_raw = CW'(MAX_SITES);
    end
    cfg.ns    = ns_raw;
    cfg.px    = periodic_mask[0];
    cfg.py    = periodic_mask[1];
    cfg.nn_x  = nn_exchange;
    cfg.nn_z  = nn_ising;
    cfg.nnn_x = nnn_exchange;
    cfg.nnn_z = nnn_ising;
  end

  // front: decode and neighbour classification, stalls only on a full queue
  slcg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .site_index (site_index),
    .stall      (full),
    .out_valid  (fr_valid),
    .out_entry  (fr_entry),
    .out_full   (q_full)
  );

  // short queue decoupling the front from the term sequencer
  slcg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (fr_valid),
    .wdata (fr_entry),
    .full  (q_full),
    .rd    (q_rd),
    .avail (q_avail),
    .rdata (q_rdata)
  );

  // back: one result beat per cycle into the output register while it is free or popped
  slcg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_avail        (q_avail),
    .q_rdata        (q_rdata),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .term_valid     (term_valid),
    .coefficient    (coef_raw),
    .left_operator  (left_operator),
    .left_site      (left_site),
    .right_operator (right_operator),
    .right_site     (right_site),
    .last_term      (last_term)
  );

endmodule

@@ tb/sv/snake_lattice_coupling_term_generator_unit_tb.sv @@
`timescale 1ns / 1ps

module snake_lattice_coupling_term_generator_unit_tb;

  localparam int SITE_W    = slcg_pkg::SITE_W;
  localparam int SIDE_W    = slcg_pkg::SIDE_W;
  localparam int COEF_W    = slcg_pkg::COEF_W;
  localparam int OP_W      = slcg_pkg::OP_W;
  localparam int REG_IDX_W = slcg_pkg::REG_IDX_W;
  localparam int DATA_W    = slcg_pkg::DATA_W;

  localparam int LIMIT_CYCLES = 300000;
  // the front pipeline plus the result queue, with margin
  localparam int SETTLE_CYCLES = 30;
  localparam int REPORT_MAX = 10;

  // one result beat as the block presents it
  typedef struct packed {
    logic              valid;
    logic [COEF_W-1:0] coef;
    logic [OP_W-1:0]   lop;
    logic [SITE_W-1:0] lsite;
    logic [OP_W-1:0]   rop;
    logic [SITE_W-1:0] rsite;
    logic              last;
  } term_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic [SITE_W-1:0]    site_index = '0;
  logic                 pop = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = slcg_pkg::REG_COLUMNS;
  logic [DATA_W-1:0]    cfg_data = '0;

  logic                     full;
  logic                     empty;
  logic                     term_valid;
  logic signed [COEF_W-1:0] coefficient;
  logic [OP_W-1:0]          left_operator;
  logic [SITE_W-1:0]        left_site;
  logic [OP_W-1:0]          right_operator;
  logic [SITE_W-1:0]        right_site;
  logic                     last_term;
  logic                     cfg_ready;

  // shadow copy of the register file, raw as written
  logic [SIDE_W-1:0] lat_cols = 7'd1;
  logic [SIDE_W-1:0] lat_rows = 7'd1;
  logic [1:0]        lat_periodic = 2'd0;
  logic [12:0]       lat_active = 13'd0;
  logic [COEF_W-1:0] j_nn_x = '0;
  logic [COEF_W-1:0] j_nn_z = '0;
  logic [COEF_W-1:0] j_nnn_x = '0;
  logic [COEF_W-1:0] j_nnn_z = '0;

  term_t expected_terms[$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    send_idle_pct = 0;
  int    pop_idle_pct = 0;

  snake_lattice_coupling_term_generator_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .site_index     (site_index),
    .empty          (empty),
    .pop            (pop),
    .term_valid     (term_valid),
    .coefficient    (coefficient),
    .left_operator  (left_operator),
    .left_site      (left_site),
    .right_operator (right_operator),
    .right_site     (right_site),
    .last_term      (last_term),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // lattice geometry and term prediction
  // ---------------------------------------------------------------------------

  // append one expected beat at the tail of the scoreboard
  function automatic void queue_term(input term_t t);
    expected_terms.insert(expected_terms.size(), t);
  endfunction

  // a side of 0 counts as 1, anything past 64 counts as 64
  function automatic int side_len(input logic [SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  // sites in use: 0 means the whole lattice, never more than the lattice holds
  function automatic int active_count();
    int total;
    int ns;
    total = side_len(lat_cols) * side_len(lat_rows);
    ns = (lat_active == 0) ? total : int'(lat_active);
    if (ns > total) ns = total;
    if (ns > 4096) ns = 4096;
    return ns;
  endfunction

  // even columns run upwards, odd columns downwards
  function automatic int snake_pos(input int x, input int y, input int ly);
    if ((x & 1) == 0) return x * ly + y;
    return (x + 1) * ly - (y + 1);
  endfunction

  // queue S+S-, S-S+ and SzSz for one pair, skipping zero couplings
  function automatic int add_pair_terms(input int site, input int other,
                                        input logic [COEF_W-1:0] exch,
                                        input logic [COEF_W-1:0] ising);
    term_t t_new;
    int    added;
    added = 0;
    for (int k = slcg_pkg::TERM_PM; k <= slcg_pkg::TERM_ZZ; k++) begin
      t_new.valid = 1'b1;
      t_new.coef  = (k == slcg_pkg::TERM_ZZ) ? ising : exch;
      t_new.lsite = SITE_W'((other < site) ? other : site);
      t_new.rsite = SITE_W'((other < site) ? site : other);
      t_new.last  = 1'b0;
      case (k)
        slcg_pkg::TERM_PM: begin
          t_new.lop = slcg_pkg::OP_RAISE;
          t_new.rop = slcg_pkg::OP_LOWER;
        end
        slcg_pkg::TERM_MP: begin
          t_new.lop = slcg_pkg::OP_LOWER;
          t_new.rop = slcg_pkg::OP_RAISE;
        end
        default: begin
          t_new.lop = slcg_pkg::OP_Z;
          t_new.rop = slcg_pkg::OP_Z;
        end
      endcase
      if (t_new.coef != 0) begin
        queue_term(t_new);
        added++;
      end
    end
    return added;
  endfunction

  // all result beats one accepted site index must produce
  function automatic void predict_site_terms(input logic [SITE_W-1:0] s);
    int    lx, ly, ns, site, ix, r, jy, jya, ixr, n, count;
    bit    px, py, up_ok, right_ok, left_ok;
    term_t none;
    lx = side_len(lat_cols);
    ly = side_len(lat_rows);
    ns = active_count();
    px = lat_periodic[0];
    py = lat_periodic[1];
    site = int'(s);
    count = 0;
    if (site < ns) begin
      ix = site / ly;
      r = site % ly;
      jy = ix[0] ? (ly - 1 - r) : r;
      up_ok = (jy < ly - 1) || py;
      right_ok = (ix < lx - 1) || px;
      left_ok = (ix >= 1) || px;
      jya = (jy + 1) % ly;
      // nearest: up, then right; a wrap onto the site itself is dropped
      if (j_nn_x != 0 || j_nn_z != 0) begin
        if (up_ok && jya != jy) begin
          n = snake_pos(ix, jya, ly);
          if (n < ns) count += add_pair_terms(site, n, j_nn_x, j_nn_z);
        end
        if (right_ok) begin
          ixr = (ix + 1) % lx;
          if (ixr != ix) begin
            n = snake_pos(ixr, jy, ly);
            if (n < ns) count += add_pair_terms(site, n, j_nn_x, j_nn_z);
          end
        end
      end
      // next-nearest: either coupling enables them, only on a true 2d lattice
      if ((j_nnn_x != 0 || j_nnn_z != 0) && lx > 1 && ly > 1) begin
        if (left_ok && up_ok) begin
          n = snake_pos((ix + lx - 1) % lx, jya, ly);
          if (n < ns) count += add_pair_terms(site, n, j_nnn_x, j_nnn_z);
        end
        if (right_ok && up_ok) begin
          n = snake_pos((ix + 1) % lx, jya, ly);
          if (n < ns) count += add_pair_terms(site, n, j_nnn_x, j_nnn_z);
        end
      end
    end
    if (count == 0) begin
      // a site with no term still answers with one empty beat
      none = '0;
      none.last = 1'b1;
      queue_term(none);
    end else begin
      expected_terms[expected_terms.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one site beat; push stays high afterwards so back-to-back beats need no toggle
  task automatic send_site(input logic [SITE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    site_index <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_site_terms(s);
  endtask

  // stop sending and let every outstanding result drain before touching registers
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      slcg_pkg::REG_COLUMNS:  lat_cols = data[SIDE_W-1:0];
      slcg_pkg::REG_ROWS:     lat_rows = data[SIDE_W-1:0];
      slcg_pkg::REG_PERIODIC: lat_periodic = data[1:0];
      slcg_pkg::REG_ACTIVE:   lat_active = data[12:0];
      slcg_pkg::REG_NN_X:     j_nn_x = data;
      slcg_pkg::REG_NN_Z:     j_nn_z = data;
      slcg_pkg::REG_NNN_X:    j_nnn_x = data;
      default:                j_nnn_z = data;
    endcase
  endtask

  // full register load, only ever done with the block drained
  task automatic load_lattice(input int cols, input int rows, input int pmask,
                              input int active, input logic [31:0] nnx,
                              input logic [31:0] nnz, input logic [31:0] nnnx,
                              input logic [31:0] nnnz);
    wait_idle();
    write_register(slcg_pkg::REG_COLUMNS, DATA_W'(cols));
    write_register(slcg_pkg::REG_ROWS, DATA_W'(rows));
    write_register(slcg_pkg::REG_PERIODIC, DATA_W'(pmask));
    write_register(slcg_pkg::REG_ACTIVE, DATA_W'(active));
    write_register(slcg_pkg::REG_NN_X, nnx);
    write_register(slcg_pkg::REG_NN_Z, nnz);
    write_register(slcg_pkg::REG_NNN_X, nnnx);
    write_register(slcg_pkg::REG_NNN_Z, nnnz);
    cfg_valid <= 1'b0;
  endtask

  // mostly small sides, some full size, a few outside the legal range
  function automatic int pick_side();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 85) return $urandom_range(64, 9);
    if (r < 92) return 64;
    return $urandom_range(127);
  endfunction

  function automatic logic [31:0] pick_coupling();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 32'h0;
    if (r < 28) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_lattice();
    int cols, rows, active, r;
    cols = pick_side();
    rows = pick_side();
    r = $urandom_range(99);
    if (r < 60) active = 0;
    else if (r < 85) active = $urandom_range(side_len(7'(cols)) * side_len(7'(rows)), 1);
    else active = $urandom_range(8191);
    load_lattice(cols, rows, $urandom_range(3), active, pick_coupling(),
                 pick_coupling(), pick_coupling(), pick_coupling());
  endtask

  // mostly live sites, some past the active count, some anywhere in 12 bits
  function automatic logic [SITE_W-1:0] pick_site();
    int ns, r;
    ns = active_count();
    r = $urandom_range(99);
    if (r < 80) return SITE_W'($urandom_range(ns - 1));
    if (r < 90 && ns < 4096) return SITE_W'($urandom_range(4095, ns));
    return SITE_W'($urandom_range(4095));
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random pop, in-order scoreboard
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  always @(posedge clk) begin : check_results
    term_t got;
    term_t want;
    if (!rst && pop && !empty) begin
      got = '{term_valid, coefficient, left_operator, left_site,
              right_operator, right_site, last_term};
      if (expected_terms.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result beat: valid=%0d coef=%h ops=%0d/%0d sites=%0d/%0d last=%0d",
                   got.valid, got.coef, got.lop, got.rop, got.lsite, got.rsite, got.last);
      end else begin
        want = expected_terms.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result mismatch at cycle %0d", cycle_count);
            $display("  expected valid=%0d coef=%h ops=%0d/%0d sites=%0d/%0d last=%0d",
                     want.valid, want.coef, want.lop, want.rop, want.lsite, want.rsite,
                     want.last);
            $display("  actual   valid=%0d coef=%h ops=%0d/%0d sites=%0d/%0d last=%0d",
                     got.valid, got.coef, got.lop, got.rop, got.lsite, got.rsite, got.last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_terms.size());
      $display("snake_lattice_coupling_term_generator_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers: 1x1 lattice, zero couplings, so every site gives an empty beat
  task automatic test_reset_defaults();
    send_site(12'd0);
    send_site(12'hfff);
  endtask

  task automatic test_directed_lattices();
    // 4x4 open, every coupling nonzero, one at the signed minimum
    load_lattice(4, 4, 0, 0, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'h8000_0000);
    send_site(12'd0);     // bottom-left corner
    send_site(12'd3);     // top of first column, no up neighbour
    send_site(12'd5);     // interior site in a downward column
    send_site(12'd15);    // last column, no right neighbour
    send_site(12'd16);    // just past the lattice
    send_site(12'hfff);
    // 4x4 periodic, one coupling of each pair zero: the nnn enable is an or
    load_lattice(4, 4, 3, 0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0000_0001);
    send_site(12'd15);
    send_site(12'd12);
    send_site(12'd0);
    // single column, periodic: right wraps onto itself and nnn stays off
    load_lattice(1, 5, 3, 0, 32'h0002_0000, 32'h0003_0000, 32'h1, 32'h1);
    send_site(12'd4);
    send_site(12'd2);
    // single row, periodic: up wraps onto itself and nnn stays off
    load_lattice(6, 1, 3, 0, 32'h0002_0000, 32'h0003_0000, 32'h1, 32'h1);
    send_site(12'd5);
    send_site(12'd0);
    // side 0 reads as 1, side 127 reads as 64; active count below the lattice
    load_lattice(0, 127, 2, 40, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
    send_site(12'd39);    // top live site, its up neighbour is past the active count
    send_site(12'd63);    // inside the lattice but past the active count
    send_site(12'd38);
    // full 64x64, active count above the lattice gets clipped
    load_lattice(127, 127, 1, 8191, 32'hdead_beef, 32'h0000_0100, 32'h8000_0000,
                 32'h7fff_ffff);
    send_site(12'd4095);
    send_site(12'd4032);
    send_site(12'd2048);
    // 2x2 periodic with one site cut: neighbours past the active count vanish
    load_lattice(2, 2, 3, 3, 32'h0001_0000, 32'h0001_0000, 32'h0000_4000, 32'h0000_4000);
    send_site(12'd0);
    send_site(12'd1);
    send_site(12'd2);
    send_site(12'd3);
  endtask

  task automatic test_random_traffic(input int lattices, input int sites_each);
    repeat (lattices) begin
      random_lattice();
      repeat (sites_each) send_site(pick_site());
    end
  endtask

  // sender holds off mid-run until the block has handed back every result
  task automatic test_drain_pause();
    random_lattice();
    repeat (10) send_site(pick_site());
    push <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (10) send_site(pick_site());
  endtask

  initial begin
    send_idle_pct = 17;
    pop_idle_pct = 76;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_lattices();
    test_random_traffic(5, 28);

    // swap the pressure: slow sender, eager receiver
    send_idle_pct = 76;
    pop_idle_pct = 17;
    test_random_traffic(5, 28);

    // full rate both ways
    send_idle_pct = 0;
    pop_idle_pct = 0;
    test_random_traffic(5, 28);
    test_drain_pause();

    wait_idle();
    if (mismatch_count == 0 && expected_terms.size() == 0) begin
      $display("snake_lattice_coupling_term_generator_unit test passed");
    end else begin
      $display("snake_lattice_coupling_term_generator_unit test failed");
    end
    $finish;
  end

endmodule
